FILE: rtl/lru_page_replacement_defines.svh
// Assertion macros for the LRU page replacement block.
// Used by lru_page_replacement; expects clk_i and rst_ni in scope.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LRU_PR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LRU_PR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lru_pr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by every module of the block.
package lru_pr_pkg;

  // Width of the frames_in_use register and its value after reset.
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

  // Fixed result field widths.
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned COUNT_W = 32;

  // Outcome of one lookup: a hit, a fill of an empty slot, or else an eviction.
  typedef struct packed {
    logic hit;
    logic fill;
  } sel_flags_t;

endpackage

FILE: rtl/lru_pr_select.sv
// Lookup logic: parallel tag compare, first empty slot and LRU victim search.
// Depends on lru_pr_pkg.
module lru_pr_select
  import lru_pr_pkg::*;
#(
  parameter int unsigned FRAME_SLOTS = 16,
  parameter int unsigned PAGE_BITS = 16,
  localparam int unsigned SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1,
  localparam int unsigned RANK_W = SLOT_W
) (
  input  logic [PAGE_BITS-1:0]                  page_i,
  input  logic [FRAME_SLOTS-1:0]                mask_i,
  input  logic [FRAME_SLOTS-1:0]                valid_i,
  input  logic [FRAME_SLOTS-1:0][PAGE_BITS-1:0] pages_i,
  input  logic [FRAME_SLOTS-1:0][RANK_W-1:0]    ranks_i,
  output sel_flags_t                            flags_o,
  output logic [SLOT_W-1:0]                     slot_o,
  output logic [PAGE_BITS-1:0]                  victim_page_o
);

  localparam int unsigned NUM_RANKS = 1 << RANK_W;

  logic [FRAME_SLOTS-1:0] match;
  logic [FRAME_SLOTS-1:0] empty;
  logic [NUM_RANKS-1:0]   rank_seen;
  logic [RANK_W-1:0]      max_rank;
  logic [SLOT_W-1:0]      hit_slot;
  logic [SLOT_W-1:0]      empty_slot;
  logic [SLOT_W-1:0]      victim_slot;

  // Per-slot match and empty flags over the active range.
  always_comb begin
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      match[j] = mask_i[j] && valid_i[j] && (pages_i[j] == page_i);
      empty[j] = mask_i[j] && !valid_i[j];
    end
  end

  // Lowest-numbered matching and empty slots; scanning downward leaves the lowest.
  always_comb begin
    hit_slot = '0;
    empty_slot = '0;
    for (int j = FRAME_SLOTS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_slot = SLOT_W'(j);
      end
      if (empty[j]) begin
        empty_slot = SLOT_W'(j);
      end
    end
  end

  // Mark which rank values occur among active slots, then take the highest.
  always_comb begin
    rank_seen = '0;
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      if (mask_i[j]) begin
        rank_seen[ranks_i[j]] = 1'b1;
      end
    end
    max_rank = '0;
    for (int v = 0; v < NUM_RANKS; v++) begin
      if (rank_seen[v]) begin
        max_rank = RANK_W'(v);
      end
    end
  end

  // The victim is the lowest-numbered active slot holding the oldest rank.
  always_comb begin
    victim_slot = '0;
    for (int j = FRAME_SLOTS - 1; j >= 0; j--) begin
      if (mask_i[j] && (ranks_i[j] == max_rank)) begin
        victim_slot = SLOT_W'(j);
      end
    end
  end

  // Combine into the chosen slot.
  always_comb begin
    flags_o.hit = |match;
    flags_o.fill = |empty;
    if (flags_o.hit) begin
      slot_o = hit_slot;
    end else if (flags_o.fill) begin
      slot_o = empty_slot;
    end else begin
      slot_o = victim_slot;
    end
  end

  assign victim_page_o = pages_i[victim_slot];

endmodule

FILE: rtl/lru_pr_frames.sv
// Frame state: resident pages, valid bits and recency ranks with their update.
// Depends on lru_pr_pkg.
module lru_pr_frames
  import lru_pr_pkg::*;
#(
  parameter int unsigned FRAME_SLOTS = 16,
  parameter int unsigned PAGE_BITS = 16,
  localparam int unsigned SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1,
  localparam int unsigned RANK_W = SLOT_W
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  apply_i,
  input  logic                                  clear_i,
  input  sel_flags_t                            flags_i,
  input  logic [SLOT_W-1:0]                     slot_i,
  input  logic [PAGE_BITS-1:0]                  page_i,
  input  logic [FRAME_SLOTS-1:0]                mask_i,
  output logic [FRAME_SLOTS-1:0]                valid_o,
  output logic [FRAME_SLOTS-1:0][PAGE_BITS-1:0] pages_o,
  output logic [FRAME_SLOTS-1:0][RANK_W-1:0]    ranks_o
);

  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(FRAME_SLOTS - 1);

  logic [FRAME_SLOTS-1:0]                valid_q, valid_d;
  logic [FRAME_SLOTS-1:0][RANK_W-1:0]    ranks_q, ranks_d;
  logic [FRAME_SLOTS-1:0][PAGE_BITS-1:0] pages_q;
  logic [RANK_W-1:0]                     slot_rank;

  assign slot_rank = ranks_q[slot_i];

  // Age the other active valid slots, then make the used slot most recent.
  // A hit only ages slots that were more recent than the hit slot; clear_i empties all.
  always_comb begin
    valid_d = valid_q;
    ranks_d = ranks_q;
    if (apply_i) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        if (mask_i[j] && valid_q[j] && (SLOT_W'(j) != slot_i) &&
            (!flags_i.hit || (ranks_q[j] < slot_rank)) && (ranks_q[j] != MAX_RANK)) begin
          ranks_d[j] = ranks_q[j] + 1'b1;
        end
      end
      ranks_d[slot_i] = '0;
      valid_d[slot_i] = 1'b1;
      if (clear_i) begin
        valid_d = '0;
        ranks_d = '0;
      end
    end
  end

  // Control state is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ranks_q <= '0;
    end else begin
      valid_q <= valid_d;
      ranks_q <= ranks_d;
    end
  end

  // Page store; an entry is only read once its valid bit is set.
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      pages_q[slot_i] <= page_i;
    end
  end

  assign valid_o = valid_q;
  assign pages_o = pages_q;
  assign ranks_o = ranks_q;

endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement unit, top level: input register, lookup, frame state,
// fault counter and result register. Depends on lru_pr_pkg, lru_pr_select,
// lru_pr_frames and lru_page_replacement_defines.svh.
//
// One page reference is taken per beat whenever start is high; busy stays low,
// so a reference may be issued in every cycle. Each reference produces exactly one
// result beat via the input and result registers, shown for a single cycle with
// result_valid_o high; the receiver cannot stall and must take it then. The
// lookup compares all active slots in parallel and updates the frames in the same
// cycle, so back-to-back references always see the effect of the one before.
// A reference flagged last_reference_i empties all frames and clears the fault
// count after its own result. Write frames_in_use only while no reference is in
// flight; 0 behaves as 1 and values above FRAME_SLOTS behave as FRAME_SLOTS.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement
  import lru_pr_pkg::*;
#(
  parameter int unsigned FRAME_SLOTS = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAGE_BITS-1:0]  page_number_i,
  input  logic                  last_reference_i,
  output logic                  result_valid_o,
  output logic                  hit_o,
  output logic [SLOT_OUT_W-1:0] frame_slot_o,
  output logic                  evicted_valid_o,
  output logic [PAGE_BITS-1:0]  evicted_page_o,
  output logic [COUNT_W-1:0]    fault_count_o
);

  localparam int unsigned SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int unsigned RANK_W = SLOT_W;
  localparam int unsigned CMP_W = 8;

  logic [CFG_W-1:0]                      frames_q;
  logic                                  in_valid_q;
  logic [PAGE_BITS-1:0]                  page_q;
  logic                                  last_q;
  logic [FRAME_SLOTS-1:0]                mask;
  logic [FRAME_SLOTS-1:0]                valid;
  logic [FRAME_SLOTS-1:0][PAGE_BITS-1:0] pages;
  logic [FRAME_SLOTS-1:0][RANK_W-1:0]    ranks;
  sel_flags_t                            flags;
  logic [SLOT_W-1:0]                     slot;
  logic [PAGE_BITS-1:0]                  victim_page;
  logic                                  evict;
  logic [COUNT_W-1:0]                    faults_q, faults_d, count_now;
  logic                                  result_valid_q;
  logic                                  hit_q;
  logic [SLOT_OUT_W-1:0]                 slot_q;
  logic                                  evicted_valid_q;
  logic [PAGE_BITS-1:0]                  evicted_page_q;
  logic [COUNT_W-1:0]                    count_q;

  // Every beat is accepted.
  assign busy = 1'b0;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      page_q <= page_number_i;
      last_q <= last_reference_i;
    end
  end

  // Active slot mask; slot 0 always takes part.
  always_comb begin
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      mask[j] = (j == 0) || (CMP_W'(j) < CMP_W'(frames_q));
    end
  end

  lru_pr_select #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_select (
    .page_i       (page_q),
    .mask_i       (mask),
    .valid_i      (valid),
    .pages_i      (pages),
    .ranks_i      (ranks),
    .flags_o      (flags),
    .slot_o       (slot),
    .victim_page_o(victim_page)
  );

  lru_pr_frames #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .apply_i(in_valid_q),
    .clear_i(last_q),
    .flags_i(flags),
    .slot_i (slot),
    .page_i (page_q),
    .mask_i (mask),
    .valid_o(valid),
    .pages_o(pages),
    .ranks_o(ranks)
  );

  assign evict = !flags.hit && !flags.fill;

  // Saturating fault counter; the result reports the count including this fault.
  always_comb begin
    count_now = faults_q;
    if (!flags.hit && !(&faults_q)) begin
      count_now = faults_q + 1'b1;
    end
    faults_d = faults_q;
    if (in_valid_q) begin
      faults_d = last_q ? '0 : count_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q <= '0;
    end else begin
      faults_q <= faults_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      hit_q <= flags.hit;
      slot_q <= SLOT_OUT_W'(slot);
      evicted_valid_q <= evict;
      evicted_page_q <= evict ? victim_page : '0;
      count_q <= count_now;
    end
  end

  assign result_valid_o = result_valid_q;
  assign hit_o = hit_q;
  assign frame_slot_o = slot_q;
  assign evicted_valid_o = evicted_valid_q;
  assign evicted_page_o = evicted_page_q;
  assign fault_count_o = count_q;

  // Checks on the result stream.
  `LRU_PR_ASSERT_NEXT(a_result_follows_input, in_valid_q, result_valid_o, "result beat missing")
  `LRU_PR_ASSERT_NEXT(a_no_spurious_result, !in_valid_q, !result_valid_o, "result without input")
  `LRU_PR_ASSERT(a_evict_only_on_fault, !(result_valid_o && evicted_valid_o && hit_o), "evict on hit")
  `LRU_PR_ASSERT(a_fault_counted, !(result_valid_o && !hit_o && (fault_count_o == '0)), "fault not counted")

endmodule
